// File: rtl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap font rasterizer package
// Types, font ROM and coordinate helpers shared by the rasterizer modules.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int CoordBits   = 16;
    localparam int CoordWide   = CoordBits + 2;
    localparam int GlyphPixels = 15;
    localparam int ScaleBits   = 7;
    localparam int ColorBits   = 32;
    localparam int CfgDataBits = 32;
    localparam int CfgIdxBits  = 2;

    localparam logic [CfgIdxBits-1:0] RegStartX = 2'd0;
    localparam logic [CfgIdxBits-1:0] RegStartY = 2'd1;
    localparam logic [CfgIdxBits-1:0] RegScale  = 2'd2;
    localparam logic [CfgIdxBits-1:0] RegColor  = 2'd3;

    localparam logic [ScaleBits-1:0] ScaleMin = 7'd1;
    localparam logic [ScaleBits-1:0] ScaleMax = 7'd64;

    localparam logic signed [CoordWide-1:0] CoordMax =
        CoordWide'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
    localparam logic signed [CoordWide-1:0] CoordMin = ~CoordMax;

    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharLowerZ = 8'h7A;
    localparam logic [7:0] CharUpperA = 8'h41;
    localparam logic [7:0] CharUpperZ = 8'h5A;
    localparam logic [7:0] CharDigit0 = 8'h30;
    localparam logic [7:0] CharDigit9 = 8'h39;
    localparam logic [7:0] CaseOffset = 8'h20;
    localparam logic [7:0] CharPeriod = 8'h2E;
    localparam logic [7:0] CharSlash  = 8'h2F;
    localparam logic [7:0] CharColon  = 8'h3A;
    localparam logic [7:0] CharMinus  = 8'h2D;
    localparam logic [7:0] CharUnder  = 8'h5F;
    localparam logic [7:0] CharPlus   = 8'h2B;
    localparam logic [7:0] CharComma  = 8'h2C;
    localparam logic [7:0] CharBang   = 8'h21;
    localparam logic [7:0] CharQuery  = 8'h3F;

    // Each octal digit is one glyph row, top row first; bit 2 is the left column.
    localparam logic [14:0] LetterRom [26] = '{
        15'o75755, 15'o65656, 15'o74447, 15'o65556, 15'o74647, 15'o74644,
        15'o74557, 15'o55755, 15'o72227, 15'o11157, 15'o56465, 15'o44447,
        15'o57755, 15'o57775, 15'o75557, 15'o75744, 15'o75571, 15'o65655,
        15'o74717, 15'o72222, 15'o55557, 15'o55522, 15'o55775, 15'o52225,
        15'o55722, 15'o71247
    };

    localparam logic [14:0] DigitRom [10] = '{
        15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
        15'o74717, 15'o74757, 15'o71244, 15'o75757, 15'o75717
    };

    localparam logic [2:0] PixRow [GlyphPixels] = '{
        3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
        3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [1:0] PixCol [GlyphPixels] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_in_string;
    } char_item_t;

    typedef struct packed {
        logic [CoordBits-1:0] rect_x;
        logic [CoordBits-1:0] rect_y;
        logic [ScaleBits-1:0] rect_size;
        logic [ColorBits-1:0] rect_color;
        logic                 last_in_char;
    } rect_item_t;

    typedef struct packed {
        logic [CoordBits-1:0] start_x;
        logic [CoordBits-1:0] start_y;
        logic [ScaleBits-1:0] scale;
        logic [ColorBits-1:0] color;
    } cfg_t;

    // Bit k of the mask is pixel k in scan order (row * 3 + column).
    typedef struct packed {
        logic [GlyphPixels-1:0] mask;
        logic [CoordBits-1:0]   pen;
    } glyph_job_t;

    function automatic logic [ScaleBits-1:0] eff_scale(input logic [ScaleBits-1:0] s);
        logic [ScaleBits-1:0] r;
        if (s < ScaleMin)
        begin
            r = ScaleMin;
        end
        else if (s > ScaleMax)
        begin
            r = ScaleMax;
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [CoordBits-1:0] sat_coord(input logic signed [CoordWide-1:0] v);
        logic [CoordBits-1:0] r;
        if (v > CoordMax)
        begin
            r = CoordMax[CoordBits-1:0];
        end
        else if (v < CoordMin)
        begin
            r = CoordMin[CoordBits-1:0];
        end
        else
        begin
            r = v[CoordBits-1:0];
        end
        return r;
    endfunction

    function automatic logic [GlyphPixels-1:0] glyph_mask(input logic [7:0] code);
        logic [7:0]             c;
        logic [14:0]            rows;
        logic [GlyphPixels-1:0] m;
        c = code;
        if (c inside {[CharLowerA:CharLowerZ]})
        begin
            c = c - CaseOffset;
        end
        if (c inside {[CharUpperA:CharUpperZ]})
        begin
            rows = LetterRom[5'(c - CharUpperA)];
        end
        else if (c inside {[CharDigit0:CharDigit9]})
        begin
            rows = DigitRom[4'(c - CharDigit0)];
        end
        else
        begin
            case (c)
                CharPeriod: rows = 15'o00002;
                CharSlash:  rows = 15'o11224;
                CharColon:  rows = 15'o02020;
                CharMinus:  rows = 15'o00700;
                CharUnder:  rows = 15'o00007;
                CharPlus:   rows = 15'o02720;
                CharComma:  rows = 15'o00022;
                CharBang:   rows = 15'o22202;
                CharQuery:  rows = 15'o71202;
                default:    rows = '0;
            endcase
        end
        for (int k = 0; k < GlyphPixels; k++)
        begin
            m[k] = rows[GlyphPixels-1-k];
        end
        return m;
    endfunction

endpackage

// File: rtl/bfr_front.sv
// ----------------------------------------------------------------------------
// Rasterizer front end
// Accepts characters, looks up the glyph mask and keeps the pen position.
// ----------------------------------------------------------------------------
module bfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  bfr_pkg::cfg_t       cfg,
    input  logic                char_valid,
    output logic                char_ready,
    input  bfr_pkg::char_item_t char_item,
    output logic                job_valid,
    input  logic                job_ready,
    output bfr_pkg::glyph_job_t job
);
    import bfr_pkg::*;

    logic [CoordBits-1:0] pen_reg;
    logic [CoordBits-1:0] pen_next;
    logic [CoordBits-1:0] base_x;
    logic                 accept;

    assign char_ready = job_ready;
    assign job_valid  = char_valid;
    assign accept     = char_valid && job_ready;
    assign base_x     = char_item.first_in_string ? cfg.start_x : pen_reg;
    assign job.mask   = glyph_mask(char_item.char_code);
    assign job.pen    = base_x;

    always_comb
    begin
        pen_next = pen_reg;
        if (accept)
        begin
            pen_next = sat_coord(CoordWide'(signed'(base_x))
                                 + CoordWide'({cfg.scale, 2'b00}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= '0;
        end
        else
        begin
            pen_reg <= pen_next;
        end
    end

endmodule

// File: rtl/bfr_queue.sv
// ----------------------------------------------------------------------------
// Rasterizer job queue
// Short register FIFO that decouples the front end from the pixel emitter.
// ----------------------------------------------------------------------------
module bfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bfr_pkg::glyph_job_t push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bfr_pkg::glyph_job_t pop_job
);
    import bfr_pkg::*;

    localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0]   LastPtr  = PtrBits'(DEPTH - 1);
    localparam logic [CountBits-1:0] FullCnt  = CountBits'(DEPTH);

    glyph_job_t           slots_reg [DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   wr_ptr_next;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_next;
    logic [CountBits-1:0] count_reg;
    logic [CountBits-1:0] count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("Queue count exceeds its depth.");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not grow on a lone push.");

endmodule

// File: rtl/bfr_back.sv
// ----------------------------------------------------------------------------
// Rasterizer pixel emitter
// Walks the lit pixels of each glyph job; emits one square per cycle unless stalled.
// ----------------------------------------------------------------------------
module bfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bfr_pkg::cfg_t       cfg,
    input  logic                job_valid,
    output logic                job_ready,
    input  bfr_pkg::glyph_job_t job,
    output logic                rect_valid,
    input  logic                rect_ready,
    output bfr_pkg::rect_item_t rect_item
);
    import bfr_pkg::*;

    logic                   cur_valid_reg;
    logic                   cur_valid_next;
    logic [GlyphPixels-1:0] cur_mask_reg;
    logic [GlyphPixels-1:0] cur_mask_next;
    logic [CoordBits-1:0]   cur_pen_reg;
    logic [CoordBits-1:0]   cur_pen_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rect_item_t             out_item_reg;
    rect_item_t             out_item_next;

    logic [GlyphPixels-1:0] low_bit;
    logic [GlyphPixels-1:0] rest;
    logic [3:0]             pix_idx;
    logic [2:0]             row;
    logic [1:0]             col;
    logic [8:0]             x_off;
    logic [8:0]             y_off;
    logic                   emit;
    logic                   cur_done;
    logic                   load;

    assign low_bit = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign rest    = cur_mask_reg & ~low_bit;

    always_comb
    begin
        pix_idx = '0;
        for (int k = 0; k < GlyphPixels; k++)
        begin
            if (low_bit[k])
            begin
                pix_idx = 4'(k);
            end
        end
    end

    assign row   = PixRow[pix_idx];
    assign col   = PixCol[pix_idx];
    assign x_off = 9'(col) * 9'(cfg.scale);
    assign y_off = 9'(row) * 9'(cfg.scale);

    assign emit      = cur_valid_reg && (cur_mask_reg != '0) && (!out_valid_reg || rect_ready);
    assign cur_done  = cur_valid_reg && ((cur_mask_reg == '0) || (emit && (rest == '0)));
    assign job_ready = !cur_valid_reg || cur_done;
    assign load      = job_valid && job_ready;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        cur_pen_next   = cur_pen_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_mask_next  = job.mask;
            cur_pen_next   = job.pen;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            cur_mask_next = rest;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_item_next.rect_x      = sat_coord(CoordWide'(signed'(cur_pen_reg))
                                                  + CoordWide'(x_off));
            out_item_next.rect_y      = sat_coord(CoordWide'(signed'(cfg.start_y))
                                                  + CoordWide'(y_off));
            out_item_next.rect_size   = cfg.scale;
            out_item_next.rect_color  = cfg.color;
            out_item_next.last_in_char = (rest == '0);
        end
        else if (rect_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mask_reg <= cur_mask_next;
        cur_pen_reg  <= cur_pen_next;
        out_item_reg <= out_item_next;
    end

    assign rect_valid = out_valid_reg;
    assign rect_item  = out_item_reg;

    a_more_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (rect_valid && rect_ready && !rect_item.last_in_char)
            |-> (cur_valid_reg && (cur_mask_reg != '0)))
        else $error("Square without last flag but no pixel left in the character.");

    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        rect_valid |-> (rect_item.rect_size >= ScaleMin) && (rect_item.rect_size <= ScaleMax))
        else $error("Square size outside the legal scale range.");

endmodule

// File: rtl/bitmap_font_text_rasterizer.sv
// ----------------------------------------------------------------------------
// Bitmap font text rasterizer
// Turns a stream of characters into filled squares using a 3x5 font.
// ----------------------------------------------------------------------------
// When the queue and the pixel emitter are empty, an accepted item passes through
// the queue slot, the emitter's job register and its output register to its first square.
// Throughput: the emitter produces one square per cycle unless rect_ready stalls it;
// each lit pixel (up to 15) gives one square, and a glyph with none still passes through.
// Reset clears the pen to zero, the registers to their defaults, and the queue.
module bitmap_font_text_rasterizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bfr_pkg::CfgIdxBits-1:0]       cfg_index,
    input  logic [bfr_pkg::CfgDataBits-1:0]      cfg_data,
    input  logic                                 char_valid,
    output logic                                 char_ready,
    input  bfr_pkg::char_item_t                  char_item,
    output logic                                 rect_valid,
    input  logic                                 rect_ready,
    output bfr_pkg::rect_item_t                  rect_item
);
    import bfr_pkg::*;

    logic [CoordBits-1:0] start_x_reg;
    logic [CoordBits-1:0] start_y_reg;
    logic [ScaleBits-1:0] scale_reg;
    logic [ColorBits-1:0] color_reg;
    cfg_t                 cfg;
    logic                 f_valid;
    logic                 f_ready;
    glyph_job_t           f_job;
    logic                 b_valid;
    logic                 b_ready;
    glyph_job_t           b_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            scale_reg   <= ScaleMin;
            color_reg   <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegStartX: start_x_reg <= cfg_data[CoordBits-1:0];
                RegStartY: start_y_reg <= cfg_data[CoordBits-1:0];
                RegScale:  scale_reg   <= cfg_data[ScaleBits-1:0];
                RegColor:  color_reg   <= cfg_data[ColorBits-1:0];
                default:   ;
            endcase
        end
    end

    assign cfg.start_x = start_x_reg;
    assign cfg.start_y = start_y_reg;
    assign cfg.scale   = eff_scale(scale_reg);
    assign cfg.color   = color_reg;

    bfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    bfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job)
    );

    bfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job        (b_job),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect_item  (rect_item)
    );

endmodule

// File: verif/bitmap_font_text_rasterizer_test.sv
// ----------------------------------------------------------------------------
// Bitmap font text rasterizer testbench
// Sends character items under random burst and stall patterns, predicts the
// squares of each glyph from a private font table and pen model, and checks
// every square in order while the registers move through several settings.
// ----------------------------------------------------------------------------
module bitmap_font_text_rasterizer_test;
    import bfr_pkg::*;

    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharHash    = 8'h23;
    localparam logic [7:0] CharAt      = 8'h40;
    localparam logic [7:0] CharBracket = 8'h5B;
    localparam logic [7:0] CharGrave   = 8'h60;
    localparam logic [7:0] CharBrace   = 8'h7B;
    localparam logic [7:0] CharNul     = 8'h00;
    localparam logic [7:0] CharDel     = 8'h7F;
    localparam logic [7:0] CharHighLo  = 8'h80;
    localparam logic [7:0] CharHighHi  = 8'hFF;

    localparam int SettleCycles = 20;
    localparam int ProbeCount   = 25;

    localparam logic [7:0] Marks [9] = '{
        CharPeriod, CharSlash, CharColon, CharMinus, CharUnder,
        CharPlus, CharComma, CharBang, CharQuery
    };

    localparam logic [7:0] Probes [ProbeCount] = '{
        CharUpperA, CharUpperZ, CharLowerA, CharLowerZ, CharDigit0, CharDigit9,
        CharPeriod, CharSlash, CharColon, CharMinus, CharUnder, CharPlus,
        CharComma, CharBang, CharQuery, CharSpace, CharHash, CharAt,
        CharBracket, CharGrave, CharBrace, CharNul, CharDel, CharHighLo,
        CharHighHi
    };

    class square_board;
        logic signed [CoordBits-1:0] origin_x;
        logic signed [CoordBits-1:0] origin_y;
        logic [ScaleBits-1:0]        scale_reg;
        logic [ColorBits-1:0]        ink;
        int                          pen_x;
        int                          errors;
        rect_item_t                  pending [$];

        function new();
            origin_x  = '0;
            origin_y  = '0;
            scale_reg = ScaleMin;
            ink       = '1;
            pen_x     = 0;
            errors    = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function int clamp(int v);
            int hi;
            hi = (1 << (CoordBits - 1)) - 1;
            if (v > hi)
            begin
                return hi;
            end
            if (v < -hi - 1)
            begin
                return -hi - 1;
            end
            return v;
        endfunction

        function logic [14:0] shape_of(logic [7:0] code);
            logic [7:0]  c;
            logic [14:0] rows;
            logic [14:0] letters [26];
            logic [14:0] digits [10];
            letters = '{
                15'o75755, 15'o65656, 15'o74447, 15'o65556, 15'o74647, 15'o74644,
                15'o74557, 15'o55755, 15'o72227, 15'o11157, 15'o56465, 15'o44447,
                15'o57755, 15'o57775, 15'o75557, 15'o75744, 15'o75571, 15'o65655,
                15'o74717, 15'o72222, 15'o55557, 15'o55522, 15'o55775, 15'o52225,
                15'o55722, 15'o71247
            };
            digits = '{
                15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
                15'o74717, 15'o74757, 15'o71244, 15'o75757, 15'o75717
            };
            c = code;
            rows = '0;
            if (c >= CharLowerA && c <= CharLowerZ)
            begin
                c = c - CaseOffset;
            end
            if (c >= CharUpperA && c <= CharUpperZ)
            begin
                rows = letters[5'(c - CharUpperA)];
            end
            else if (c >= CharDigit0 && c <= CharDigit9)
            begin
                rows = digits[4'(c - CharDigit0)];
            end
            else
            begin
                case (c)
                    CharPeriod: rows = 15'o00002;
                    CharSlash:  rows = 15'o11224;
                    CharColon:  rows = 15'o02020;
                    CharMinus:  rows = 15'o00700;
                    CharUnder:  rows = 15'o00007;
                    CharPlus:   rows = 15'o02720;
                    CharComma:  rows = 15'o00022;
                    CharBang:   rows = 15'o22202;
                    CharQuery:  rows = 15'o71202;
                    default:    rows = '0;
                endcase
            end
            return rows;
        endfunction

        function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
            case (idx)
                RegStartX: origin_x  = data[CoordBits-1:0];
                RegStartY: origin_y  = data[CoordBits-1:0];
                RegScale:  scale_reg = data[ScaleBits-1:0];
                RegColor:  ink       = data[ColorBits-1:0];
                default:   ;
            endcase
        endfunction

        function void note_char(char_item_t item);
            logic [14:0] rows;
            rect_item_t  sq;
            int          side;
            int          lit;
            int          seen;
            side = int'(scale_reg);
            if (side < ScaleMin)
            begin
                side = int'(ScaleMin);
            end
            if (side > ScaleMax)
            begin
                side = int'(ScaleMax);
            end
            if (item.first_in_string)
            begin
                pen_x = int'(origin_x);
            end
            rows = shape_of(item.char_code);
            lit = $countones(rows);
            seen = 0;
            for (int k = 0; k < GlyphPixels; k++)
            begin
                if (rows[GlyphPixels-1-k])
                begin
                    seen++;
                    sq.rect_x       = 16'(clamp(pen_x + (k % 3) * side));
                    sq.rect_y       = 16'(clamp(int'(origin_y) + (k / 3) * side));
                    sq.rect_size    = 7'(side);
                    sq.rect_color   = ink;
                    sq.last_in_char = (seen == lit);
                    pending.push_back(sq);
                end
            end
            pen_x = clamp(pen_x + 4 * side);
        endfunction

        function void check_square(rect_item_t got);
            rect_item_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected square x=%h y=%h size=%0d color=%h last=%0b",
                    got.rect_x, got.rect_y, got.rect_size, got.rect_color,
                    got.last_in_char));
                return;
            end
            want = pending.pop_front();
            if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y
                    || got.rect_size !== want.rect_size
                    || got.rect_color !== want.rect_color
                    || got.last_in_char !== want.last_in_char)
            begin
                report($sformatf({"square mismatch: expected x=%h y=%h size=%0d color=%h ",
                    "last=%0b, got x=%h y=%h size=%0d color=%h last=%0b"},
                    want.rect_x, want.rect_y, want.rect_size, want.rect_color,
                    want.last_in_char, got.rect_x, got.rect_y, got.rect_size,
                    got.rect_color, got.last_in_char));
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CfgIdxBits-1:0]  cfg_index = RegStartX;
    logic [CfgDataBits-1:0] cfg_data = '0;
    logic                   char_valid = 1'b0;
    logic                   char_ready;
    char_item_t             char_item = '0;
    logic                   rect_valid;
    logic                   rect_ready = 1'b0;
    rect_item_t             rect_item;

    square_board board = new();
    int          burst_left = 0;
    int          string_left = 0;
    int          stall_pct = 0;
    int          mode_left = 0;

    bitmap_font_text_rasterizer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect_item  (rect_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rect_valid && rect_ready)
            begin
                board.check_square(rect_item);
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2:    stall_pct = 25;
                    3:    stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                mode_left = $urandom_range(20, 150);
            end
            else
            begin
                mode_left--;
            end
            rect_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                             input logic [CfgDataBits-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [CfgDataBits-1:0] sx, input logic [CfgDataBits-1:0] sy,
                              input logic [CfgDataBits-1:0] sc, input logic [CfgDataBits-1:0] col);
        write_reg(RegStartX, sx);
        write_reg(RegStartY, sy);
        write_reg(RegScale, sc);
        write_reg(RegColor, col);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_char(input logic [7:0] code, input logic first);
        char_item_t item;
        int         gap;
        item.char_code       = code;
        item.first_in_string = first;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        char_valid <= 1'b1;
        char_item  <= item;
        @(posedge clk);
        while (!char_ready) @(posedge clk);
        board.note_char(item);
    endtask

    task automatic drain();
        char_valid <= 1'b0;
        burst_left = 0;
        while (board.pending.size() > 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 11))
            0, 1, 2, 3: return CharUpperA + 8'($urandom_range(0, 25));
            4, 5:       return CharLowerA + 8'($urandom_range(0, 25));
            6, 7:       return CharDigit0 + 8'($urandom_range(0, 9));
            8, 9:       return Marks[4'($urandom_range(0, 8))];
            10:         return CharSpace;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_text(input int count);
        logic first;
        for (int i = 0; i < count; i++)
        begin
            first = 1'b0;
            if (string_left == 0)
            begin
                first = 1'b1;
                string_left = $urandom_range(1, 12);
            end
            string_left--;
            if ($urandom_range(0, 15) == 0)
            begin
                first = 1'($urandom_range(0, 1));
            end
            send_char(pick_char(), first);
        end
    endtask

    task automatic random_phase();
        logic [CfgDataBits-1:0] sx;
        logic [CfgDataBits-1:0] sy;
        logic [CfgDataBits-1:0] sc;
        sx = $urandom();
        sy = $urandom();
        sc = $urandom();
        case ($urandom_range(0, 9))
            0:       sc[ScaleBits-1:0] = '0;
            1:       sc[ScaleBits-1:0] = 7'($urandom_range(64, 127));
            2:       sc[ScaleBits-1:0] = 7'($urandom_range(7, 63));
            default: sc[ScaleBits-1:0] = 7'($urandom_range(1, 6));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            sx[CoordBits-1:0] = 16'h7F00 + 16'($urandom_range(0, 255));
        end
        set_config(sx, sy, sc, $urandom());
        string_left = 0;
        send_text(50);
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ProbeCount; i++)
        begin
            send_char(Probes[i], (i == 0) || (i == 13));
        end
        drain();

        set_config(32'h0000_7FFF, 32'h0000_7FFF, 32'd64, 32'h0000_0000);
        send_text(6);
        drain();
        set_config(32'hFFFF_8000, 32'hFFFF_8000, 32'd0, 32'hFFFF_FFFF);
        string_left = 0;
        send_text(6);
        drain();
        set_config(32'h0000_7F00, 32'h0000_7FF0, 32'd127, 32'hA5A5_5A5A);
        string_left = 0;
        send_text(6);
        drain();
        set_config(32'hFFFF_FFF0, 32'h0000_0010, 32'd65, 32'h1234_5678);
        string_left = 0;
        send_text(6);
        drain();

        repeat (6) random_phase();

        if (board.pending.size() > 0)
        begin
            board.report($sformatf("%0d squares never arrived", board.pending.size()));
        end
        if (board.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #16_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
